>>> rtl/avsd_pkg.sv
// ----------------------------------------------------------------------------
// Averaging voltmeter package
// Shared constants, record types and display helpers for the voltmeter block.
// ----------------------------------------------------------------------------
package avsd_pkg;

    // Group size and internal queue depth defaults.
    localparam int AVERAGE_COUNT_DEF = 4;
    localparam int QUEUE_DEPTH_DEF   = 2;

    // Field widths fixed by the interface.
    localparam int SAMPLE_W  = 10;
    localparam int PERIOD_W  = 8;
    localparam int SEG_W     = 7;
    localparam int VOLT_W    = 6;
    localparam int DIGIT_W   = 4;

    // Widest running sum over the supported group sizes (16 * 1023).
    localparam int MAX_SUM_W = 14;

    // Reset value of the conversion period register.
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd25;

    // Reciprocal scaling used to divide the sum by the group size.
    localparam int RECIP_SHIFT = 18;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    // Scale factor and converter full-scale value.
    localparam int SCALE_MUL   = 33;
    localparam int FULL_SCALE  = 1023;

    // Result kinds.
    localparam logic KIND_DISPLAY = 1'b0;
    localparam logic KIND_READING = 1'b1;

    // Input modes.
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    // Work record passed from the front end to the back end.
    typedef struct packed {
        logic                 kind;
        logic                 show_high;
        logic                 start;
        logic [MAX_SUM_W-1:0] sum;
    } work_rec_t;

    // Result record as seen on the output ports.
    typedef struct packed {
        logic              kind;
        logic [SEG_W-1:0]  segments;
        logic              en_high;
        logic              en_low;
        logic              start;
        logic [VOLT_W-1:0] volt;
    } result_rec_t;

    // Seven-segment pattern for one hexadecimal digit, bit 0 is segment a.
    function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] code;
        begin
            case (digit)
                4'h0:    code = 7'h3F;
                4'h1:    code = 7'h06;
                4'h2:    code = 7'h5B;
                4'h3:    code = 7'h4F;
                4'h4:    code = 7'h66;
                4'h5:    code = 7'h6D;
                4'h6:    code = 7'h7D;
                4'h7:    code = 7'h07;
                4'h8:    code = 7'h7F;
                4'h9:    code = 7'h6F;
                4'hA:    code = 7'h77;
                4'hB:    code = 7'h7C;
                4'hC:    code = 7'h39;
                4'hD:    code = 7'h5E;
                4'hE:    code = 7'h79;
                default: code = 7'h71;
            endcase
            return code;
        end
    endfunction

    // Tens digit of a 6-bit value: (v * 13) >> 7 is exact for v below 64.
    function automatic logic [DIGIT_W-1:0] tens_of(input logic [VOLT_W-1:0] v);
        logic [10:0] prod;
        begin
            prod = 11'(v) * 11'd13;
            return DIGIT_W'(prod >> 7);
        end
    endfunction

    // Units digit of a 6-bit value.
    function automatic logic [DIGIT_W-1:0] units_of(input logic [VOLT_W-1:0] v);
        logic [VOLT_W-1:0] tens_x10;
        logic [VOLT_W-1:0] rem;
        begin
            tens_x10 = VOLT_W'(tens_of(v)) * VOLT_W'(10);
            rem      = v - tens_x10;
            return DIGIT_W'(rem);
        end
    endfunction

endpackage

>>> rtl/avsd_queue.sv
// ----------------------------------------------------------------------------
// Voltmeter record queue
// Small first-in first-out store for records of any packed type.
// ----------------------------------------------------------------------------
module avsd_queue #(
    parameter type T     = logic,
    parameter int  DEPTH = avsd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  T     wr_data,
    output logic full,
    input  logic rd_en,
    output T     rd_data,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    T                 mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    // A transfer only takes place on the side that is able to take it.
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;

    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointer and occupancy updates, wrapping at the depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> rtl/avsd_front.sv
// ----------------------------------------------------------------------------
// Voltmeter front end
// Accepts samples and ticks, sums each group, runs the digit and request
// counters and issues one work record for every item that gives a result.
// ----------------------------------------------------------------------------
module avsd_front #(
    parameter int AVERAGE_COUNT = avsd_pkg::AVERAGE_COUNT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_take,
    input  logic                            mode,
    input  logic [avsd_pkg::SAMPLE_W-1:0]   adc_sample,
    input  logic                            cfg_wr_en,
    input  logic [avsd_pkg::PERIOD_W-1:0]   cfg_wr_data,
    output logic                            rec_valid,
    output avsd_pkg::work_rec_t             rec
);

    localparam int SUM_W = $clog2(AVERAGE_COUNT * avsd_pkg::FULL_SCALE + 1);
    localparam int CNT_W = $clog2(AVERAGE_COUNT + 1);
    localparam int PW    = avsd_pkg::PERIOD_W;

    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             show_high_reg;
    logic             show_high_next;
    logic [PW-1:0]    tick_reg;
    logic [PW-1:0]    tick_next;
    logic [PW-1:0]    period_reg;
    logic [SUM_W-1:0] sum_added;
    logic             group_done;
    logic [PW:0]      tick_inc;
    logic [PW:0]      period_eff;

    // Running sum including the sample now being taken.
    assign sum_added  = sum_reg + SUM_W'(adc_sample);
    assign group_done = (cnt_reg == CNT_W'(AVERAGE_COUNT - 1));

    // A period of zero behaves as a full turn of the 8-bit counter.
    assign tick_inc   = {1'b0, tick_reg} + 1'b1;
    assign period_eff = (period_reg == '0) ? {1'b1, {PW{1'b0}}} : {1'b0, period_reg};

    // State updates for each accepted item.
    always_comb
    begin
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        show_high_next = show_high_reg;
        tick_next      = tick_reg;
        rec_valid      = 1'b0;
        rec.kind       = avsd_pkg::KIND_DISPLAY;
        rec.show_high  = show_high_reg;
        rec.start      = (tick_reg == '0);
        rec.sum        = avsd_pkg::MAX_SUM_W'(sum_added);
        if (in_take)
        begin
            if (mode == avsd_pkg::MODE_SAMPLE)
            begin
                if (group_done)
                begin
                    sum_next  = '0;
                    cnt_next  = '0;
                    rec_valid = 1'b1;
                    rec.kind  = avsd_pkg::KIND_READING;
                end
                else
                begin
                    sum_next = sum_added;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            else
            begin
                rec_valid      = 1'b1;
                show_high_next = !show_high_reg;
                tick_next      = (tick_inc >= period_eff) ? '0 : PW'(tick_inc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            cnt_reg       <= '0;
            show_high_reg <= 1'b0;
            tick_reg      <= '0;
            period_reg    <= avsd_pkg::PERIOD_RESET;
        end
        else
        begin
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            show_high_reg <= show_high_next;
            tick_reg      <= tick_next;
            if (cfg_wr_en)
            begin
                period_reg <= cfg_wr_data;
            end
        end
    end

endmodule

>>> rtl/avsd_back.sv
// ----------------------------------------------------------------------------
// Voltmeter back end
// Turns work records into results: scales a finished group into tenths of a
// volt via prod_reg and ST_SCALE, and builds the display drive for each tick.
// ----------------------------------------------------------------------------
module avsd_back #(
    parameter int AVERAGE_COUNT = avsd_pkg::AVERAGE_COUNT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rec_ready,
    input  avsd_pkg::work_rec_t   rec,
    output logic                  rec_take,
    input  logic                  res_full,
    output logic                  res_valid,
    output avsd_pkg::result_rec_t res
);

    localparam int SHIFT  = avsd_pkg::RECIP_SHIFT;
    localparam int RW     = avsd_pkg::RECIP_W;
    localparam int SW     = avsd_pkg::MAX_SUM_W;
    localparam int PROD_W = SW + RW;
    localparam int AVG_W  = avsd_pkg::SAMPLE_W;
    localparam int VW     = avsd_pkg::VOLT_W;
    localparam int X_W    = 16;
    localparam logic [RW-1:0] RECIP =
        RW'(((1 << SHIFT) + AVERAGE_COUNT - 1) / AVERAGE_COUNT);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_SCALE = 2'b10
    } back_state_t;

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [PROD_W-1:0] prod_reg;
    logic [VW-1:0]     volt_reg;
    logic [VW-1:0]     volt_next;
    logic [AVG_W-1:0]  avg;
    logic [X_W-1:0]    scaled;
    logic [VW-1:0]     quot_est;
    logic [X_W-1:0]    rem_est;
    logic [VW-1:0]     volt_calc;
    logic [avsd_pkg::DIGIT_W-1:0] digit;

    // Average by reciprocal multiply; exact for every sum in range.
    assign avg = prod_reg[SHIFT +: AVG_W];

    // Scale by 33, then divide by 1023: x >> 10 is low by at most one.
    assign scaled    = (X_W'(avg) << 5) + X_W'(avg);
    assign quot_est  = scaled[X_W-1:10];
    assign rem_est   = scaled - {quot_est, 10'b0} + X_W'(quot_est);
    assign volt_calc = (rem_est >= X_W'(avsd_pkg::FULL_SCALE)) ? quot_est + 1'b1 : quot_est;

    assign digit = rec.show_high ? avsd_pkg::tens_of(volt_reg) : avsd_pkg::units_of(volt_reg);

    // Records are taken one a cycle when idle and the output queue has room.
    always_comb
    begin
        state_next   = state_reg;
        volt_next    = volt_reg;
        rec_take     = 1'b0;
        res_valid    = 1'b0;
        res.kind     = avsd_pkg::KIND_DISPLAY;
        res.segments = avsd_pkg::seg_code(digit);
        res.en_high  = rec.show_high;
        res.en_low   = !rec.show_high;
        res.start    = rec.start;
        res.volt     = volt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (rec_ready && !res_full)
                begin
                    rec_take = 1'b1;
                    if (rec.kind == avsd_pkg::KIND_READING)
                    begin
                        state_next = ST_SCALE;
                    end
                    else
                    begin
                        res_valid = 1'b1;
                    end
                end
            end
            ST_SCALE:
            begin
                // Room was checked when the record was taken.
                volt_next    = volt_calc;
                res_valid    = 1'b1;
                res.kind     = avsd_pkg::KIND_READING;
                res.segments = '0;
                res.en_high  = 1'b0;
                res.en_low   = 1'b0;
                res.start    = 1'b0;
                res.volt     = volt_calc;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            volt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            volt_reg  <= volt_next;
        end
    end

    // First scaling step for a finished group.
    always_ff @(posedge clk)
    begin
        if (rec_take)
        begin
            prod_reg <= PROD_W'(rec.sum) * PROD_W'(RECIP);
        end
    end

endmodule

>>> rtl/averaging_voltmeter_seven_segment.sv
// ----------------------------------------------------------------------------
// Averaging voltmeter with two-digit seven-segment drive
// Averages groups of converter samples into tenths of a volt and drives a
// multiplexed two-digit display on each refresh tick.
//
//   Channel   Direction  Handshake            Contents
//   input     in         push / full          mode, adc_sample
//   result    out        pop / empty          result_kind, segments, enables,
//                                             start_conversion, voltage_tenths
//   config    in         cfg_wr_en            cfg_wr_data (conversion period)
//
// One item is accepted per cycle while full is low. A tick result passes
// through the work queue and then the output queue; a reading also passes
// through the back end's product register and scale state, and the back
// end takes no other record while it scales a finished group.
// Reset is asynchronous: both queues empty, counters clear, period is 25.
// A stalled result side fills the output queue, then the work queue, and
// then full is raised.
// ----------------------------------------------------------------------------
module averaging_voltmeter_seven_segment #(
    parameter int AVERAGE_COUNT = avsd_pkg::AVERAGE_COUNT_DEF,
    parameter int QUEUE_DEPTH   = avsd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          mode,
    input  logic [avsd_pkg::SAMPLE_W-1:0] adc_sample,
    input  logic                          pop,
    output logic                          empty,
    output logic                          result_kind,
    output logic [avsd_pkg::SEG_W-1:0]    segments,
    output logic                          enable_high_digit,
    output logic                          enable_low_digit,
    output logic                          start_conversion,
    output logic [avsd_pkg::VOLT_W-1:0]   voltage_tenths,
    input  logic                          cfg_wr_en,
    input  logic [avsd_pkg::PERIOD_W-1:0] cfg_wr_data
);

    logic                  in_take;
    logic                  rec_valid;
    avsd_pkg::work_rec_t   rec_in;
    avsd_pkg::work_rec_t   rec_out;
    logic                  work_full;
    logic                  work_empty;
    logic                  rec_take;
    logic                  res_valid;
    logic                  res_full;
    avsd_pkg::result_rec_t res_in;
    avsd_pkg::result_rec_t res_out;

    // An input transfer is taken whenever the work queue has room.
    assign full    = work_full;
    assign in_take = push && !work_full;

    avsd_front #(
        .AVERAGE_COUNT (AVERAGE_COUNT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_take     (in_take),
        .mode        (mode),
        .adc_sample  (adc_sample),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rec_valid   (rec_valid),
        .rec         (rec_in)
    );

    // Work queue between front and back end.
    avsd_queue #(
        .T     (avsd_pkg::work_rec_t),
        .DEPTH (QUEUE_DEPTH)
    ) u_work_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rec_valid),
        .wr_data (rec_in),
        .full    (work_full),
        .rd_en   (rec_take),
        .rd_data (rec_out),
        .empty   (work_empty)
    );

    avsd_back #(
        .AVERAGE_COUNT (AVERAGE_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_ready (!work_empty),
        .rec       (rec_out),
        .rec_take  (rec_take),
        .res_full  (res_full),
        .res_valid (res_valid),
        .res       (res_in)
    );

    // Output queue holding finished results for the consumer.
    avsd_queue #(
        .T     (avsd_pkg::result_rec_t),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_out),
        .empty   (empty)
    );

    assign result_kind       = res_out.kind;
    assign segments          = res_out.segments;
    assign enable_high_digit = res_out.en_high;
    assign enable_low_digit  = res_out.en_low;
    assign start_conversion  = res_out.start;
    assign voltage_tenths    = res_out.volt;

endmodule

>>> tb/sv/averaging_voltmeter_seven_segment_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Averaging voltmeter with seven-segment drive: self-checking test
// Feeds converter samples and refresh ticks through the input queue. It
// forecasts every reading and display drive from its own model of the sample
// groups, the digit multiplexing and the conversion request counter, and
// compares each popped result field by field. It also steps the conversion
// period through its extremes between phases.
// ----------------------------------------------------------------------------
module averaging_voltmeter_seven_segment_test;

    localparam int GROUP_SIZE   = 4;
    localparam int VOLT_SCALE   = 33;
    localparam int ADC_FULL     = 1023;
    localparam int PHASE_ITEMS  = 180;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 1000000;

    // Forecast of the block: sample groups, stored voltage and display state.
    class display_forecast;
        avsd_pkg::result_rec_t awaited_results[$];
        int unsigned group_sum;
        int unsigned group_fill;
        int unsigned volt_now;
        int unsigned tick_pos;
        int unsigned period_reg;
        bit          tens_next;
        int unsigned mismatches;

        function new();
            group_sum  = 0;
            group_fill = 0;
            volt_now   = 0;
            tick_pos   = 0;
            period_reg = 25;
            tens_next  = 1'b0;
            mismatches = 0;
        endfunction

        // Segment pattern of one digit, bit 0 is segment a.
        function logic [avsd_pkg::SEG_W-1:0] glyph_of(input int unsigned digit);
            case (digit)
                0:       return 7'h3F;
                1:       return 7'h06;
                2:       return 7'h5B;
                3:       return 7'h4F;
                4:       return 7'h66;
                5:       return 7'h6D;
                6:       return 7'h7D;
                7:       return 7'h07;
                8:       return 7'h7F;
                9:       return 7'h6F;
                10:      return 7'h77;
                11:      return 7'h7C;
                12:      return 7'h39;
                13:      return 7'h5E;
                14:      return 7'h79;
                default: return 7'h71;
            endcase
        endfunction

        // Works out what one accepted item produces and queues it.
        function void accept_item(input logic item_mode,
                                  input logic [avsd_pkg::SAMPLE_W-1:0] sample);
            avsd_pkg::result_rec_t drive;
            int unsigned span;
            int unsigned digit;
            drive = '0;
            if (item_mode == avsd_pkg::MODE_SAMPLE)
            begin
                group_sum += 32'(sample);
                group_fill++;
                if (group_fill == GROUP_SIZE)
                begin
                    volt_now   = ((group_sum / GROUP_SIZE) * VOLT_SCALE) / ADC_FULL;
                    group_sum  = 0;
                    group_fill = 0;
                    drive.kind = avsd_pkg::KIND_READING;
                    drive.volt = volt_now[avsd_pkg::VOLT_W-1:0];
                    awaited_results.push_back(drive);
                end
            end
            else
            begin
                // A period of zero lets the counter run through all 256 values.
                span           = (period_reg == 0) ? 256 : period_reg;
                digit          = tens_next ? (volt_now / 10) % 16 : (volt_now % 10);
                drive.kind     = avsd_pkg::KIND_DISPLAY;
                drive.segments = glyph_of(digit);
                drive.en_high  = tens_next;
                drive.en_low   = !tens_next;
                drive.start    = (tick_pos == 0);
                drive.volt     = volt_now[avsd_pkg::VOLT_W-1:0];
                awaited_results.push_back(drive);
                tens_next = !tens_next;
                tick_pos++;
                if (tick_pos >= span)
                begin
                    tick_pos = 0;
                end
            end
        endfunction

        function void check_field(input string name, input int unsigned want,
                                  input int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        // Compares one popped result with the oldest forecast.
        function void compare_result(input avsd_pkg::result_rec_t got);
            avsd_pkg::result_rec_t want;
            if (awaited_results.size() == 0)
            begin
                $error("result popped with none outstanding: kind %0d volt %0d",
                       got.kind, got.volt);
                mismatches++;
                return;
            end
            want = awaited_results.pop_front();
            check_field("result_kind", 32'(want.kind), 32'(got.kind));
            check_field("segments", 32'(want.segments), 32'(got.segments));
            check_field("enable_high_digit", 32'(want.en_high), 32'(got.en_high));
            check_field("enable_low_digit", 32'(want.en_low), 32'(got.en_low));
            check_field("start_conversion", 32'(want.start), 32'(got.start));
            check_field("voltage_tenths", 32'(want.volt), 32'(got.volt));
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          push;
    logic                          full;
    logic                          mode;
    logic [avsd_pkg::SAMPLE_W-1:0] adc_sample;
    logic                          pop;
    logic                          empty;
    logic                          result_kind;
    logic [avsd_pkg::SEG_W-1:0]    segments;
    logic                          enable_high_digit;
    logic                          enable_low_digit;
    logic                          start_conversion;
    logic [avsd_pkg::VOLT_W-1:0]   voltage_tenths;
    logic                          cfg_wr_en;
    logic [avsd_pkg::PERIOD_W-1:0] cfg_wr_data;

    display_forecast forecast;
    bit              sender_steady;
    int              cycle_count;

    averaging_voltmeter_seven_segment i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .mode              (mode),
        .adc_sample        (adc_sample),
        .pop               (pop),
        .empty             (empty),
        .result_kind       (result_kind),
        .segments          (segments),
        .enable_high_digit (enable_high_digit),
        .enable_low_digit  (enable_low_digit),
        .start_conversion  (start_conversion),
        .voltage_tenths    (voltage_tenths),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Guard against a hang.
    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("averaging_voltmeter_seven_segment_test: done, errors");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
        begin
            return 0;
        end
        if (roll < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Offers one item after an optional gap and waits for its transfer.
    task automatic send_item(input logic item_mode,
                             input logic [avsd_pkg::SAMPLE_W-1:0] sample);
        int gap;
        gap = sender_steady ? 0 : pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push       <= 1'b1;
        mode       <= item_mode;
        adc_sample <= sample;
        do
        begin
            @(posedge clk);
        end
        while (full);
        forecast.accept_item(item_mode, sample);
    endtask

    // Lets the block drain, then writes the conversion period.
    task automatic write_period(input logic [avsd_pkg::PERIOD_W-1:0] value);
        @(negedge clk);
        push <= 1'b0;
        while (forecast.awaited_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES)
        begin
            @(negedge clk);
        end
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        forecast.period_reg = 32'(value);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Random mix of ticks and samples; samples often cluster round a level
    // so that the readings spread over the whole voltage range.
    task automatic run_phase(input int count);
        int                            level;
        int                            k;
        logic [avsd_pkg::SAMPLE_W-1:0] sample;
        sender_steady = ($urandom_range(0, 3) == 0);
        level         = $urandom_range(0, ADC_FULL);
        for (k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                level = $urandom_range(0, ADC_FULL);
            end
            case ($urandom_range(0, 7))
                0:       sample = '0;
                1:       sample = '1;
                2, 3, 4: sample = level[avsd_pkg::SAMPLE_W-1:0];
                default: sample = avsd_pkg::SAMPLE_W'($urandom_range(0, ADC_FULL));
            endcase
            send_item($urandom_range(0, 1) ? avsd_pkg::MODE_TICK : avsd_pkg::MODE_SAMPLE,
                      sample);
        end
    endtask

    // Result side: random stalls, with spells of steady popping.
    initial
    begin : result_side
        int stall;
        int spell_left;
        bit steady;
        stall      = 0;
        spell_left = 0;
        steady     = 1'b0;
        forever
        begin
            @(negedge clk);
            if (spell_left == 0)
            begin
                steady     = ($urandom_range(0, 3) == 0);
                spell_left = $urandom_range(20, 200);
            end
            spell_left--;
            if (stall > 0)
            begin
                stall--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
                if (!steady)
                begin
                    stall = pick_gap();
                end
            end
        end
    end

    // Check every result transfer.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            forecast.compare_result({result_kind, segments, enable_high_digit,
                                     enable_low_digit, start_conversion, voltage_tenths});
        end
    end

    // Main sequence.
    initial
    begin : stimulus
        int k;
        forecast      = new();
        sender_steady = 1'b0;
        rst_n         = 1'b0;
        push          = 1'b0;
        mode          = avsd_pkg::MODE_SAMPLE;
        adc_sample    = '0;
        pop           = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        repeat (11)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: ticks before any reading, full scale, zero, a mixed
        // group with alternating bit patterns, and a reading of exactly 1.0 V.
        send_item(avsd_pkg::MODE_TICK, '0);
        send_item(avsd_pkg::MODE_TICK, '1);
        for (k = 0; k < GROUP_SIZE; k++)
        begin
            send_item(avsd_pkg::MODE_SAMPLE, 10'd1023);
        end
        send_item(avsd_pkg::MODE_TICK, '0);
        send_item(avsd_pkg::MODE_TICK, '0);
        for (k = 0; k < GROUP_SIZE; k++)
        begin
            send_item(avsd_pkg::MODE_SAMPLE, 10'd0);
        end
        send_item(avsd_pkg::MODE_SAMPLE, 10'h155);
        send_item(avsd_pkg::MODE_SAMPLE, 10'h2AA);
        send_item(avsd_pkg::MODE_SAMPLE, 10'd0);
        send_item(avsd_pkg::MODE_SAMPLE, 10'd1023);
        send_item(avsd_pkg::MODE_TICK, '0);
        send_item(avsd_pkg::MODE_TICK, '0);
        for (k = 0; k < GROUP_SIZE; k++)
        begin
            send_item(avsd_pkg::MODE_SAMPLE, 10'd310);
        end
        send_item(avsd_pkg::MODE_TICK, '0);
        send_item(avsd_pkg::MODE_TICK, '0);

        // Random phases over several conversion periods.
        run_phase(PHASE_ITEMS);
        write_period(8'd255);
        run_phase(PHASE_ITEMS);
        write_period(8'd0);
        run_phase(PHASE_ITEMS);
        // Bring the tick counter well past the next, lower, period.
        while (forecast.tick_pos < 40)
        begin
            send_item(avsd_pkg::MODE_TICK,
                      avsd_pkg::SAMPLE_W'($urandom_range(0, ADC_FULL)));
        end
        write_period(8'd5);
        run_phase(PHASE_ITEMS);
        write_period(8'd1);
        run_phase(PHASE_ITEMS);
        write_period(8'd2);
        run_phase(PHASE_ITEMS);
        write_period(avsd_pkg::PERIOD_W'($urandom_range(1, 255)));
        run_phase(PHASE_ITEMS);
        write_period(8'd25);
        run_phase(PHASE_ITEMS);

        // Drain and let any stray result show up.
        @(negedge clk);
        push <= 1'b0;
        while (forecast.awaited_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES)
        begin
            @(posedge clk);
        end
        if (forecast.mismatches == 0)
        begin
            $display("averaging_voltmeter_seven_segment_test: done, clean");
        end
        else
        begin
            $display("averaging_voltmeter_seven_segment_test: done, errors");
        end
        $finish;
    end

endmodule
